// ===== src/bcd_pkg.sv =====
package bcd_pkg;

    localparam int VERTEX_W = 8;
    localparam int COUNT_W  = 9;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef enum logic [2:0] {
        ST_STORED        = 3'd0,
        ST_FULL          = 3'd1,
        ST_BIPARTITE     = 3'd2,
        ST_NOT_BIPARTITE = 3'd3,
        ST_RANGE         = 3'd4
    } t_status;

    typedef struct packed {
        logic                func;
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] dst;
    } t_req;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_rsp;

endpackage

// ===== src/bcd_core.sv =====
module bcd_core #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  bcd_pkg::t_req               i_req,
    input  logic                        i_out_free,
    input  logic [bcd_pkg::COUNT_W-1:0] i_vertex_count,
    output logic                        o_idle,
    output bcd_pkg::t_rsp               o_rsp
);
    import bcd_pkg::*;

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int CW0  = $clog2(MAX_VERTICES + 1);
    localparam int CNTW = (CW0 > COUNT_W) ? CW0 : COUNT_W;
    localparam int SPW  = $clog2(MAX_VERTICES + 1);
    localparam int EW   = $clog2(MAX_EDGES + 1);
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam logic [EW-1:0] NULL_EDGE = EW'(MAX_EDGES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_WR,
        S_START,
        S_START_CHK,
        S_EDGE,
        S_POP,
        S_EDGE_RD,
        S_NBR,
        S_HOLD,
        S_CLEAR
    } t_state;

    logic [EW-1:0]    head_mem  [MAX_VERTICES];
    logic [1:0]       mark_mem  [MAX_VERTICES];
    logic [VW+EW-1:0] edge_mem  [MAX_EDGES];
    logic [EW:0]      stack_mem [MAX_VERTICES];

    logic [VW-1:0]    va;
    logic             head_we;
    logic [EW-1:0]    head_wd;
    logic [EW-1:0]    head_rd;
    logic             mark_we;
    logic [1:0]       mark_wd;
    logic [1:0]       mark_rd;
    logic [EAW-1:0]   ea;
    logic             edge_we;
    logic [VW+EW-1:0] edge_wd;
    logic [VW+EW-1:0] edge_rd;
    logic [VW-1:0]    sa;
    logic             stack_we;
    logic [EW:0]      stack_wd;
    logic [EW:0]      stack_rd;

    t_state        r_state,  n_state;
    t_state        r_after,  n_after;
    t_status       r_status, n_status;
    logic [CNTW-1:0] r_v,    n_v;
    logic [SPW-1:0]  r_sp,   n_sp;
    logic [EW-1:0]   r_e,    n_e;
    logic            r_side, n_side;
    logic [EW-1:0]   r_used, n_used;
    logic [VW-1:0]   r_clr,  n_clr;
    logic [VW-1:0]   r_w,    n_w;
    logic [VERTEX_W-1:0] r_src, n_src;
    logic [VERTEX_W-1:0] r_dst, n_dst;

    logic [CNTW-1:0] vc_ext;
    logic [CNTW-1:0] count;
    logic            fin;
    t_status         fin_status;
    t_state          fin_after;
    logic [VW-1:0]   nbr_w;
    logic [EW-1:0]   nbr_link;

    assign vc_ext = CNTW'(i_vertex_count);
    assign count  = (vc_ext > CNTW'(MAX_VERTICES)) ? CNTW'(MAX_VERTICES) : vc_ext;
    assign {nbr_w, nbr_link} = edge_rd;

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[va] <= head_wd;
        end
        head_rd <= head_mem[va];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mark_mem[va] <= mark_wd;
        end
        mark_rd <= mark_mem[va];
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[ea] <= edge_wd;
        end
        edge_rd <= edge_mem[ea];
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            stack_mem[sa] <= stack_wd;
        end
        stack_rd <= stack_mem[sa];
    end

    always_comb begin
        n_state    = r_state;
        n_after    = r_after;
        n_status   = r_status;
        n_v        = r_v;
        n_sp       = r_sp;
        n_e        = r_e;
        n_side     = r_side;
        n_used     = r_used;
        n_clr      = r_clr;
        n_w        = r_w;
        n_src      = r_src;
        n_dst      = r_dst;
        va         = r_w;
        head_we    = 1'b0;
        head_wd    = NULL_EDGE;
        mark_we    = 1'b0;
        mark_wd    = 2'b00;
        ea         = r_e[EAW-1:0];
        edge_we    = 1'b0;
        edge_wd    = {VW'(r_dst), head_rd};
        sa         = VW'(r_sp - SPW'(1));
        stack_we   = 1'b0;
        stack_wd   = {r_e, r_side};
        fin        = 1'b0;
        fin_status = ST_BIPARTITE;
        fin_after  = S_IDLE;
        o_rsp      = '0;

        unique case (r_state)
            S_IDLE: begin
                va = VW'(i_req.src);
                if (i_start) begin
                    n_src = i_req.src;
                    n_dst = i_req.dst;
                    if (i_req.func == FUNC_ADD) begin
                        n_state = S_ADD_WR;
                    end else begin
                        n_v     = '0;
                        n_state = S_START;
                    end
                end
            end
            S_ADD_WR: begin
                va  = VW'(r_src);
                ea  = r_used[EAW-1:0];
                fin = 1'b1;
                if (CNTW'(r_src) >= count || CNTW'(r_dst) >= count) begin
                    fin_status = ST_RANGE;
                end else if (r_used == NULL_EDGE) begin
                    fin_status = ST_FULL;
                end else begin
                    edge_we    = 1'b1;
                    head_we    = 1'b1;
                    head_wd    = r_used;
                    n_used     = r_used + EW'(1);
                    fin_status = ST_STORED;
                end
            end
            S_START: begin
                va = r_v[VW-1:0];
                if (r_v >= count) begin
                    fin        = 1'b1;
                    fin_status = ST_BIPARTITE;
                    fin_after  = S_CLEAR;
                end else begin
                    n_state = S_START_CHK;
                end
            end
            S_START_CHK: begin
                va = r_v[VW-1:0];
                if (mark_rd[1]) begin
                    n_v     = r_v + CNTW'(1);
                    n_state = S_START;
                end else begin
                    mark_we = 1'b1;
                    mark_wd = 2'b10;
                    n_e     = head_rd;
                    n_side  = 1'b0;
                    n_sp    = SPW'(1);
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                if (r_e >= r_used) begin
                    if (r_sp == SPW'(1)) begin
                        n_sp    = '0;
                        n_v     = r_v + CNTW'(1);
                        n_state = S_START;
                    end else begin
                        sa      = VW'(r_sp - SPW'(2));
                        n_sp    = r_sp - SPW'(1);
                        n_state = S_POP;
                    end
                end else begin
                    n_state = S_EDGE_RD;
                end
            end
            S_POP: begin
                {n_e, n_side} = stack_rd;
                n_state       = S_EDGE;
            end
            S_EDGE_RD: begin
                n_e = nbr_link;
                n_w = nbr_w;
                va  = nbr_w;
                if (CNTW'(nbr_w) >= count) begin
                    n_state = S_EDGE;
                end else begin
                    n_state = S_NBR;
                end
            end
            S_NBR: begin
                n_state = S_EDGE;
                if (!mark_rd[1]) begin
                    mark_we = 1'b1;
                    mark_wd = {1'b1, ~r_side};
                    if (r_sp != SPW'(MAX_VERTICES)) begin
                        stack_we = 1'b1;
                        n_e      = head_rd;
                        n_side   = ~r_side;
                        n_sp     = r_sp + SPW'(1);
                    end
                end else if (mark_rd[0] == r_side) begin
                    fin        = 1'b1;
                    fin_status = ST_NOT_BIPARTITE;
                    fin_after  = S_CLEAR;
                end
            end
            S_HOLD: begin
                fin        = 1'b1;
                fin_status = r_status;
                fin_after  = r_after;
            end
            S_CLEAR: begin
                va      = r_clr;
                head_we = 1'b1;
                mark_we = 1'b1;
                n_clr   = r_clr + VW'(1);
                if (r_clr == VW'(MAX_VERTICES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (fin_after == S_CLEAR) begin
                n_used = '0;
                n_clr  = '0;
                n_sp   = '0;
            end
            if (i_out_free) begin
                o_rsp.valid  = 1'b1;
                o_rsp.status = fin_status;
                n_state      = fin_after;
            end else begin
                n_status = fin_status;
                n_after  = fin_after;
                n_state  = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_after <= S_IDLE;
            r_clr   <= '0;
            r_used  <= '0;
            r_sp    <= '0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_clr   <= n_clr;
            r_used  <= n_used;
            r_sp    <= n_sp;
        end
        r_status <= n_status;
        r_v      <= n_v;
        r_e      <= n_e;
        r_side   <= n_side;
        r_w      <= n_w;
        r_src    <= n_src;
        r_dst    <= n_dst;
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// ===== src/bipartite_check_dfs.sv =====
// Bipartite check by depth-first two-coloring over stored directed edges.
// Input channel: i_valid / o_stall carry one item (i_func, i_src_vertex,
// i_dst_vertex). i_func add stores an edge at the front of the source's
// list; i_func check colors the graph, reports, then clears all edges.
// Output channel: o_valid / i_stall carry one o_status per input item.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into vertex_count; write
// it only while the block is idle.
// An add reads the list head memory when accepted, writes it in S_ADD_WR,
// then its status enters the output register, raising o_valid; no new
// item is taken until that read-then-write is done. A check runs a sequencer
// over single-port memories, trying each start vertex, walking edges and
// popping the stack, then a clear sweep over all MAX_VERTICES entries runs
// before the next item is taken. After reset the same clear sweep runs with
// o_stall high; vertex_count resets to zero.
// A result waits in the output register while i_stall is high; the block
// takes the next item meanwhile and holds its own result until the
// register frees.
module bipartite_check_dfs #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_func,
    input  logic [bcd_pkg::VERTEX_W-1:0] i_src_vertex,
    input  logic [bcd_pkg::VERTEX_W-1:0] i_dst_vertex,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    input  logic                         i_cfg_wr_en,
    input  logic [bcd_pkg::COUNT_W-1:0]  i_cfg_wr_data
);
    import bcd_pkg::*;

    logic [COUNT_W-1:0] r_vertex_count;
    logic               r_out_valid;
    t_status            r_out_status;
    logic               core_idle;
    logic               out_free;
    logic               accept;
    t_req               req;
    t_rsp               rsp;

    assign o_stall  = !core_idle;
    assign accept   = i_valid && core_idle;
    assign out_free = !r_out_valid || !i_stall;
    assign req      = '{func: i_func, src: i_src_vertex, dst: i_dst_vertex};

    bcd_core #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (accept),
        .i_req          (req),
        .i_out_free     (out_free),
        .i_vertex_count (r_vertex_count),
        .o_idle         (core_idle),
        .o_rsp          (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_vertex_count <= i_cfg_wr_data;
            end
            if (rsp.valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (rsp.valid) begin
            r_out_status <= rsp.status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;

endmodule
